// ===== rtl/dhp_pkg.sv =====
// Shared constants for the d-ary min-heap core.
`timescale 1ns / 1ps
`default_nettype none
package dhp_pkg;
	localparam int CAPACITY_DEF  = 1024;
	localparam int MAX_ARITY_DEF = 8;
	localparam int PRIO_W   = 32;
	localparam int HANDLE_W = 16;
	localparam int INDEX_W  = 10;
	localparam int ARITY_W  = 4;
	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 2;
	localparam int ENTRY_W  = PRIO_W + HANDLE_W;

	localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_APPEND  = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_REBUILD = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_INDEX = 2'd3;
endpackage
`default_nettype wire

// ===== rtl/dhp_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module dhp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// ===== rtl/d_ary_min_heap_core.sv =====
// Top level of the d-ary min-heap priority queue core.
// An error or an empty rebuild goes straight to the result word; an append writes the entry at
// the end. Insert moves each parent that is not smaller down until one is smaller or it reaches
// the root. Remove reads the indexed and last entries, then sifts down, scanning the children
// of each level. Rebuild sifts down every node from the last to the root. One command at a time.
// Reset (arst_n low) empties the heap and sets the arity to 2; the store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module d_ary_min_heap_core #(
	parameter int CAPACITY  = dhp_pkg::CAPACITY_DEF,
	parameter int MAX_ARITY = dhp_pkg::MAX_ARITY_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [dhp_pkg::FUNC_W-1:0]    func,
	input  wire logic [dhp_pkg::PRIO_W-1:0]    item_priority,
	input  wire logic [dhp_pkg::HANDLE_W-1:0]  item_handle,
	input  wire logic [dhp_pkg::INDEX_W-1:0]   index,
	input  wire logic                          cfg_we,
	input  wire logic [dhp_pkg::ARITY_W-1:0]   cfg_wdata,
	output logic                               done,
	output logic [dhp_pkg::STATUS_W-1:0]       status,
	output logic [dhp_pkg::PRIO_W-1:0]         out_priority,
	output logic [dhp_pkg::HANDLE_W-1:0]       out_handle,
	output logic [$clog2(CAPACITY+1)-1:0]      count
);
	import dhp_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY+1);
	// Positions are carried one bit wider so that child indices can run past the end.
	localparam int PW = CW + 1;
	// Shift of the reciprocal used for the parent index.
	localparam int RS = PW + ARITY_W;

	// Sequencer states.
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_UPRD  = 4'd1;  // read parent
	localparam logic [3:0] S_UPWT  = 4'd2;  // compute parent index
	localparam logic [3:0] S_UPCMP = 4'd3;  // compare and write hole slot
	localparam logic [3:0] S_RMRD  = 4'd4;  // read indexed entry
	localparam logic [3:0] S_RMLST = 4'd5;  // read last entry, or the node to sift on rebuild
	localparam logic [3:0] S_RMWT  = 4'd6;
	localparam logic [3:0] S_DNCUR = 4'd7;  // read first child
	localparam logic [3:0] S_DNCH  = 4'd8;  // scan children one per cycle
	localparam logic [3:0] S_DNSW  = 4'd9;  // write child into current slot
	localparam logic [3:0] S_DONE  = 4'd10;
	localparam logic [3:0] S_DNWT  = 4'd11;
	localparam logic [3:0] S_DNCW  = 4'd12;
	localparam logic [3:0] S_RBNXT = 4'd13;

	logic [3:0]            state_q;
	logic [ARITY_W-1:0]    arity_q;
	logic [CW-1:0]         count_q;
	logic [FUNC_W-1:0]     func_q;
	logic [PW-1:0]         pos_q;      // node being sifted
	logic [PW-1:0]         par_q;
	logic [PW-1:0]         kid_q;      // child being read
	logic [PW-1:0]         kid_end_q;
	logic [PW-1:0]         best_q;
	logic [ENTRY_W-1:0]    best_e_q;
	logic [ENTRY_W-1:0]    cur_e_q;    // entry carried along the sift path
	logic [PW-1:0]         rb_q;       // rebuild position
	logic                  first_q;
	logic                  deeper_q;   // the sift has moved below its starting node

	logic                  ram_we;
	logic [AW-1:0]         ram_addr;
	logic [ENTRY_W-1:0]    ram_wdata;
	logic [ENTRY_W-1:0]    ram_rdata;

	dhp_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Effective arity with the zero and saturation rules.
	logic [ARITY_W-1:0] d_eff;
	always_comb begin
		if (arity_q == '0) begin
			d_eff = ARITY_W'(1);
		end else if (32'(arity_q) > MAX_ARITY) begin
			d_eff = ARITY_W'(MAX_ARITY);
		end else begin
			d_eff = arity_q;
		end
	end

	// The parent (pos - 1) / d comes from a multiply by the rounded-up reciprocal of d and a
	// shift. With RS bits of shift the rounding error stays below one step for every position,
	// so the quotient is exact.
	logic [RS:0] recip;
	always_comb begin
		recip = '0;
		for (int k = 1; k < (1 << ARITY_W); k++) begin
			if (d_eff == ARITY_W'(k)) begin
				recip = (RS+1)'(((64'd1 << RS) + 64'(k) - 64'd1) / 64'(k));
			end
		end
	end

	logic [PW-1:0] pos_m1;
	assign pos_m1 = pos_q - PW'(1);

	logic [PW+RS:0] par_prod;
	assign par_prod = (PW+RS+1)'(pos_m1) * (PW+RS+1)'(recip);

	// First child of a position: pos*d + 1, one narrow multiply.
	logic [PW+ARITY_W-1:0] first_kid;
	assign first_kid = (PW+ARITY_W)'(pos_q) * (PW+ARITY_W)'(d_eff) + (PW+ARITY_W)'(1);

	logic [PRIO_W-1:0] rd_prio, best_prio, cur_prio;
	assign rd_prio   = ram_rdata[ENTRY_W-1 -: PRIO_W];
	assign best_prio = best_e_q[ENTRY_W-1 -: PRIO_W];
	assign cur_prio  = cur_e_q[ENTRY_W-1 -: PRIO_W];

	logic [STATUS_W-1:0] res_status_q;
	logic [ENTRY_W-1:0]  res_e_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = AW'(pos_q);
		ram_wdata = cur_e_q;
		case (state_q)
			S_UPRD:  ram_addr = AW'(par_q);
			S_UPCMP: begin
				// Parent not smaller: parent moves down into pos; else cur lands at pos.
				ram_addr  = AW'(pos_q);
				ram_we    = 1'b1;
				ram_wdata = (rd_prio < cur_prio) ? cur_e_q : ram_rdata;
			end
			S_RMRD:  ram_addr = AW'(pos_q);
			// Remove reads the last entry; rebuild reads the node it is about to sift.
			S_RMLST: ram_addr = (func_q == FUNC_REBUILD) ? AW'(pos_q) : AW'(count_q);
			S_DNCUR: ram_addr = AW'(kid_q);
			S_DNCH:  ram_addr = AW'(kid_q);
			S_DNSW: begin
				ram_addr  = AW'(pos_q);
				ram_we    = 1'b1;
				ram_wdata = best_e_q;
			end
			S_DNCW: begin
				ram_addr  = AW'(pos_q);
				ram_we    = 1'b1;
				ram_wdata = cur_e_q;
			end
			S_RBNXT: ram_addr = AW'(rb_q);
			default: ram_addr = AW'(pos_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			arity_q <= ARITY_W'(2);
			count_q <= '0;
			done    <= 1'b0;
		end else begin
			done <= (state_q == S_DONE);
			if (cfg_we) begin
				arity_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						func_q  <= func;
						cur_e_q <= {item_priority, item_handle};
						res_e_q <= '0;
						if (func == FUNC_INSERT || func == FUNC_APPEND) begin
							if (32'(count_q) >= CAPACITY) begin
								res_status_q <= ST_FULL;
								state_q      <= S_DONE;
							end else begin
								res_status_q <= ST_OK;
								pos_q        <= PW'(count_q);
								count_q      <= count_q + CW'(1);
								if (func == FUNC_APPEND || count_q == '0) begin
									state_q <= S_DNCW;
								end else begin
									state_q <= S_UPWT;
								end
							end
						end else if (func == FUNC_REMOVE) begin
							if (count_q == '0) begin
								res_status_q <= ST_EMPTY;
								state_q      <= S_DONE;
							end else if (32'(index) >= 32'(count_q)) begin
								res_status_q <= ST_INDEX;
								state_q      <= S_DONE;
							end else begin
								res_status_q <= ST_OK;
								pos_q        <= PW'(index);
								count_q      <= count_q - CW'(1);
								state_q      <= S_RMRD;
							end
						end else begin
							res_status_q <= ST_OK;
							rb_q         <= PW'(count_q);
							state_q      <= (count_q != '0) ? S_RBNXT : S_DONE;
						end
					end
				end
				// Parent index of the hole, registered from the reciprocal multiply.
				S_UPWT: begin
					par_q   <= par_prod[RS +: PW];
					state_q <= S_UPRD;
				end
				S_UPRD: state_q <= S_UPCMP;
				S_UPCMP: begin
					if (rd_prio < cur_prio) begin
						state_q <= S_DONE;
					end else begin
						pos_q   <= par_q;
						state_q <= (par_q == '0) ? S_DNCW : S_UPWT;
					end
				end
				S_RMRD: state_q <= S_RMLST;
				S_RMLST: begin
					// Rebuild removes nothing, so its answer word stays zero.
					res_e_q  <= (func_q == FUNC_REBUILD) ? '0 : ram_rdata;
					deeper_q <= 1'b0;
					state_q  <= S_RMWT;
				end
				S_RMWT: begin
					// The carried entry is loaded only at the start of a sift.
					if (!deeper_q) begin
						cur_e_q <= ram_rdata;
					end
					kid_q   <= first_kid[PW-1:0];
					first_q <= 1'b1;
					if ({{ARITY_W{1'b0}}, PW'(count_q)} <= first_kid) begin
						state_q <= S_DNCW;
					end else begin
						kid_end_q <= first_kid[PW-1:0] + PW'(d_eff);
						state_q   <= S_DNCUR;
					end
				end
				// Start the child scan; read data arrives in the cycle after its address.
				S_DNCUR: begin
					kid_q   <= kid_q + PW'(1);
					best_q  <= kid_q;
					state_q <= S_DNCH;
				end
				S_DNCH: begin
					if (first_q || best_prio > rd_prio) begin
						if (!first_q) begin
							best_q <= kid_q - PW'(1);
						end
						best_e_q <= ram_rdata;
					end
					first_q <= 1'b0;
					if (kid_q == kid_end_q || kid_q >= PW'(count_q)) begin
						state_q <= S_DNWT;
					end else begin
						kid_q <= kid_q + PW'(1);
					end
				end
				S_DNWT: begin
					// Last compare done in S_DNCH on the final read.
					state_q <= (best_prio < cur_prio) ? S_DNSW : S_DNCW;
				end
				S_DNSW: begin
					pos_q    <= best_q;
					deeper_q <= 1'b1;
					state_q  <= S_RMWT;
				end
				S_DNCW: begin
					if (func_q == FUNC_REBUILD && rb_q != '0) begin
						state_q <= S_RBNXT;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_RBNXT: begin
					rb_q    <= rb_q - PW'(1);
					pos_q   <= rb_q - PW'(1);
					state_q <= S_RMLST;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign status       = res_status_q;
	assign out_priority = res_e_q[ENTRY_W-1 -: PRIO_W];
	assign out_handle   = res_e_q[HANDLE_W-1:0];
	assign count        = count_q;
endmodule
`default_nettype wire

// ===== rtl/dhp_checker.sv =====
// Port-level assertions for the heap core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module dhp_checker #(
	parameter int CW = 11
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire logic          busy,
	input wire logic          done,
	input wire logic [1:0]    status,
	input wire logic [CW-1:0] count
);
	import dhp_pkg::*;

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("start not taken");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	a_err_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> $stable(count)) else $error("error changed count");
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !start |=> $stable(count)) else $error("idle count moved");
endmodule

bind d_ary_min_heap_core dhp_checker #(.CW($clog2(CAPACITY+1))) u_dhp_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .count(count)
);
`default_nettype wire
